// ===== rtl/core/sqvg_pkg.sv =====
package sqvg_pkg;

   localparam int IDX_W    = 8;
   localparam int ISUM_W   = IDX_W + 1;
   localparam int RADIUS_W = 16;
   localparam int POS_W    = 17;
   localparam int NORM_W   = 16;
   localparam int SLOT_W   = 3;
   localparam int PROD_W   = 34;

   localparam int DEF_STACKS = 20;
   localparam int DEF_SLICES = 20;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [SLOT_W-1:0] FIRST_SLOT = 3'd0;
   localparam logic [SLOT_W-1:0] LAST_SLOT  = 3'd5;

   // corner order 01, 02, 11, 02, 12, 11: bit k belongs to slot k
   localparam logic [5:0] CORNER_DLAT = 6'b110100;
   localparam logic [5:0] CORNER_DLON = 6'b011010;

   localparam longint PI_Q30  = 64'sd3373259426;
   localparam longint ONE_Q30 = 64'sd1073741824;

   localparam longint SIN_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};
   localparam longint COS_DIV [1:8] = '{2, 12, 30, 56, 90, 132, 182, 240};

   typedef struct packed {
      logic [IDX_W-1:0] stack_index;
      logic [IDX_W-1:0] slice_index;
      logic             index_error;
   } item_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] sin_lat;
      logic signed [NORM_W-1:0] cos_lat;
      logic signed [NORM_W-1:0] sin_lon;
      logic signed [NORM_W-1:0] cos_lon;
   } trig_type;

   // Q30 Taylor series on a reduced angle, quadrant applied, rounded to Q1.15
   function automatic logic signed [NORM_W-1:0] sin_poly(input longint t,
                                                         input logic [1:0] quad);
      longint t2;
      longint term;
      longint s;
      longint c;
      longint v;
      longint m;
      logic   neg;
      t2   = (t * t) >>> 30;
      term = t;
      s    = t;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * t2) >>> 30) / SIN_DIV[k];
         s    = (k % 2 == 1) ? s - term : s + term;
      end
      term = ONE_Q30;
      c    = ONE_Q30;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * t2) >>> 30) / COS_DIV[k];
         c    = (k % 2 == 1) ? c - term : c + term;
      end
      case (quad)
         2'd0:    v = s;
         2'd1:    v = c;
         2'd2:    v = -s;
         default: v = -c;
      endcase
      neg = (v < 0);
      m   = neg ? -v : v;
      m   = (m + 64'sd16384) >>> 15;
      if (!neg && m > 64'sd32767) m = 64'sd32767;
      if (neg && m > 64'sd32768) m = 64'sd32768;
      return neg ? NORM_W'(-m) : NORM_W'(m);
   endfunction

   // round p / 2^15 to nearest, ties away from zero
   function automatic logic signed [PROD_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
      logic                     neg;
      logic signed [PROD_W-1:0] mag;
      neg = p[PROD_W-1];
      mag = neg ? -p : p;
      mag = (mag + PROD_W'(16384)) >>> 15;
      return neg ? -mag : mag;
   endfunction

endpackage

// ===== rtl/core/sqvg_front.sv =====
module sqvg_front #(
   parameter int STACKS = sqvg_pkg::DEF_STACKS,
   parameter int SLICES = sqvg_pkg::DEF_SLICES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sqvg_pkg::IDX_W-1:0]     req_stack_index,
   input  logic [sqvg_pkg::IDX_W-1:0]     req_slice_index,
   output logic                           head_valid,
   output sqvg_pkg::item_type             head,
   input  logic                           head_pop
);

   localparam int PTR_W = $clog2(sqvg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sqvg_pkg::QUEUE_DEPTH + 1);

   sqvg_pkg::item_type entry_ff [sqvg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   sqvg_pkg::item_type item;
   logic               push;

   always_comb begin
      item.stack_index = req_stack_index;
      item.slice_index = req_slice_index;
      item.index_error =
         ({1'b0, req_stack_index} >= sqvg_pkg::ISUM_W'(STACKS)) ||
         ({1'b0, req_slice_index} >= sqvg_pkg::ISUM_W'(SLICES));
   end

   assign req_ready  = (count_ff != CNT_W'(sqvg_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sqvg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sqvg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) head_pop |-> head_valid)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(sqvg_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// ===== rtl/core/sqvg_trig.sv =====
module sqvg_trig #(
   parameter int STACKS = sqvg_pkg::DEF_STACKS,
   parameter int SLICES = sqvg_pkg::DEF_SLICES,
   parameter int LAT_W  = $clog2(STACKS + 1),
   parameter int LON_W  = $clog2(SLICES)
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [LAT_W-1:0]    lat_idx,
   input  logic [LON_W-1:0]    lon_idx,
   output sqvg_pkg::trig_type  trig
);

   localparam longint LatDen = 4 * STACKS;
   localparam longint LonDen = 4 * SLICES;

   logic signed [sqvg_pkg::NORM_W-1:0] sin_lat_tab [STACKS + 1];
   logic signed [sqvg_pkg::NORM_W-1:0] cos_lat_tab [STACKS + 1];
   logic signed [sqvg_pkg::NORM_W-1:0] sin_lon_tab [SLICES];
   logic signed [sqvg_pkg::NORM_W-1:0] cos_lon_tab [SLICES];
   sqvg_pkg::trig_type                 trig_ff;

   for (genvar gi = 0; gi <= STACKS; gi++) begin : g_lat
      localparam longint SN = 2 * gi - STACKS;
      localparam longint SR = ((SN % LatDen) + LatDen) % LatDen;
      localparam longint SQ = (4 * SR) / LatDen;
      localparam longint SM = 4 * SR - SQ * LatDen;
      localparam longint ST = (SM * sqvg_pkg::PI_Q30 + LatDen) / (2 * LatDen);
      localparam longint CN = 2 * gi;
      localparam longint CR = ((CN % LatDen) + LatDen) % LatDen;
      localparam longint CQ = (4 * CR) / LatDen;
      localparam longint CM = 4 * CR - CQ * LatDen;
      localparam longint CT = (CM * sqvg_pkg::PI_Q30 + LatDen) / (2 * LatDen);
      assign sin_lat_tab[gi] = sqvg_pkg::sin_poly(ST, 2'(SQ));
      assign cos_lat_tab[gi] = sqvg_pkg::sin_poly(CT, 2'(CQ));
   end

   for (genvar gj = 0; gj < SLICES; gj++) begin : g_lon
      localparam longint SN = 4 * gj;
      localparam longint SR = SN % LonDen;
      localparam longint SQ = (4 * SR) / LonDen;
      localparam longint SM = 4 * SR - SQ * LonDen;
      localparam longint ST = (SM * sqvg_pkg::PI_Q30 + LonDen) / (2 * LonDen);
      localparam longint CN = 4 * gj + SLICES;
      localparam longint CR = CN % LonDen;
      localparam longint CQ = (4 * CR) / LonDen;
      localparam longint CM = 4 * CR - CQ * LonDen;
      localparam longint CT = (CM * sqvg_pkg::PI_Q30 + LonDen) / (2 * LonDen);
      assign sin_lon_tab[gj] = sqvg_pkg::sin_poly(ST, 2'(SQ));
      assign cos_lon_tab[gj] = sqvg_pkg::sin_poly(CT, 2'(CQ));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff.sin_lat <= sin_lat_tab[lat_idx];
         trig_ff.cos_lat <= cos_lat_tab[lat_idx];
         trig_ff.sin_lon <= sin_lon_tab[lon_idx];
         trig_ff.cos_lon <= cos_lon_tab[lon_idx];
      end
   end

   assign trig = trig_ff;

endmodule

// ===== rtl/core/sqvg_back.sv =====
module sqvg_back #(
   parameter int STACKS = sqvg_pkg::DEF_STACKS,
   parameter int SLICES = sqvg_pkg::DEF_SLICES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  sqvg_pkg::item_type                   head,
   output logic                                 head_pop,
   input  logic [sqvg_pkg::RADIUS_W-1:0]        radius,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sqvg_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [sqvg_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [sqvg_pkg::POS_W-1:0]    rsp_pos_z,
   output logic signed [sqvg_pkg::NORM_W-1:0]   rsp_norm_x,
   output logic signed [sqvg_pkg::NORM_W-1:0]   rsp_norm_y,
   output logic signed [sqvg_pkg::NORM_W-1:0]   rsp_norm_z,
   output logic [sqvg_pkg::SLOT_W-1:0]          rsp_corner_slot,
   output logic                                 rsp_index_error,
   output logic                                 rsp_run_last
);

   localparam int LAT_W  = $clog2(STACKS + 1);
   localparam int LON_W  = $clog2(SLICES);
   localparam int ISUM_W = sqvg_pkg::ISUM_W;
   localparam int PROD_W = sqvg_pkg::PROD_W;
   localparam int NORM_W = sqvg_pkg::NORM_W;
   localparam int POS_W  = sqvg_pkg::POS_W;
   localparam int SLOT_W = sqvg_pkg::SLOT_W;

   logic                      adv;
   logic                      issue;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [ISUM_W-1:0]         lat_sum;
   logic [ISUM_W-1:0]         lon_sum;
   logic [LAT_W-1:0]          lat_idx;
   logic [LON_W-1:0]          lon_idx;
   sqvg_pkg::trig_type        trig;

   logic                      s1_valid_ff;
   logic [SLOT_W-1:0]         s1_slot_ff;
   logic                      s1_err_ff;

   logic                      s2_valid_ff;
   logic [SLOT_W-1:0]         s2_slot_ff;
   logic                      s2_err_ff;
   logic signed [NORM_W-1:0]  s2_nx_ff, s2_ny_ff, s2_nz_ff;
   logic signed [NORM_W-1:0]  nx_in, ny_in, nz_in;

   logic                      out_valid_ff;
   logic signed [POS_W-1:0]   px_ff, py_ff, pz_ff;
   logic signed [POS_W-1:0]   px_in, py_in, pz_in;
   logic signed [NORM_W-1:0]  nx_ff, ny_ff, nz_ff;
   logic [SLOT_W-1:0]         out_slot_ff;
   logic                      out_err_ff;

   logic signed [2*NORM_W-1:0]       prod_nx, prod_ny;
   logic signed [POS_W-1:0]          rad_s;
   logic signed [POS_W+NORM_W-1:0]   prod_px, prod_py, prod_pz;

   assign adv      = !out_valid_ff || rsp_ready;
   assign issue    = adv && head_valid;
   assign head_pop = issue && (slot_ff == sqvg_pkg::LAST_SLOT);

   always_comb begin
      slot_in = slot_ff;
      if (issue) begin
         slot_in = (slot_ff == sqvg_pkg::LAST_SLOT) ? sqvg_pkg::FIRST_SLOT : slot_ff + 1'b1;
      end
   end

   always_comb begin
      lat_sum = ISUM_W'(head.stack_index) + ISUM_W'(sqvg_pkg::CORNER_DLAT[slot_ff]);
      lon_sum = ISUM_W'(head.slice_index) + ISUM_W'(sqvg_pkg::CORNER_DLON[slot_ff]);
      lat_idx = head.index_error ? '0 : LAT_W'(lat_sum);
      // a full turn wraps back to the first longitude edge
      lon_idx = (head.index_error || lon_sum == ISUM_W'(SLICES)) ? '0 : LON_W'(lon_sum);
   end

   sqvg_trig #(
      .STACKS (STACKS),
      .SLICES (SLICES),
      .LAT_W  (LAT_W),
      .LON_W  (LON_W)
   ) u_trig (
      .clock   (clock),
      .enable  (issue),
      .lat_idx (lat_idx),
      .lon_idx (lon_idx),
      .trig    (trig)
   );

   always_comb begin
      prod_nx = trig.cos_lat * trig.cos_lon;
      prod_ny = trig.cos_lat * trig.sin_lon;
      nx_in   = NORM_W'(sqvg_pkg::round_q15(PROD_W'(prod_nx)));
      ny_in   = NORM_W'(sqvg_pkg::round_q15(PROD_W'(prod_ny)));
      nz_in   = trig.sin_lat;
      if (s1_err_ff) begin
         nx_in = '0;
         ny_in = '0;
         nz_in = '0;
      end
   end

   always_comb begin
      rad_s   = signed'({1'b0, radius});
      prod_px = rad_s * s2_nx_ff;
      prod_py = rad_s * s2_ny_ff;
      prod_pz = rad_s * s2_nz_ff;
      px_in   = POS_W'(sqvg_pkg::round_q15(PROD_W'(prod_px)));
      py_in   = POS_W'(sqvg_pkg::round_q15(PROD_W'(prod_py)));
      pz_in   = POS_W'(sqvg_pkg::round_q15(PROD_W'(prod_pz)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= sqvg_pkg::FIRST_SLOT;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         if (adv) begin
            s1_valid_ff  <= head_valid;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_slot_ff  <= slot_ff;
         s1_err_ff   <= head.index_error;
         s2_slot_ff  <= s1_slot_ff;
         s2_err_ff   <= s1_err_ff;
         s2_nx_ff    <= nx_in;
         s2_ny_ff    <= ny_in;
         s2_nz_ff    <= nz_in;
         out_slot_ff <= s2_slot_ff;
         out_err_ff  <= s2_err_ff;
         px_ff       <= px_in;
         py_ff       <= py_in;
         pz_ff       <= pz_in;
         nx_ff       <= s2_nx_ff;
         ny_ff       <= s2_ny_ff;
         nz_ff       <= s2_nz_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_pos_z       = pz_ff;
   assign rsp_norm_x      = nx_ff;
   assign rsp_norm_y      = ny_ff;
   assign rsp_norm_z      = nz_ff;
   assign rsp_corner_slot = out_slot_ff;
   assign rsp_index_error = out_err_ff;
   assign rsp_run_last    = (out_slot_ff == sqvg_pkg::LAST_SLOT);

   assert property (@(posedge clock) disable iff (reset) slot_ff <= sqvg_pkg::LAST_SLOT)
      else $error("corner sequencer out of range");

   assert property (@(posedge clock) disable iff (reset)
      slot_ff != sqvg_pkg::FIRST_SLOT && !head_valid |-> 1'b0)
      else $error("queue head lost in the middle of a run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |->
         rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0 &&
         rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0)
      else $error("out-of-grid transaction carries geometry");

   assert property (@(posedge clock) disable iff (reset)
      issue && $past(issue) && $past(slot_ff) != sqvg_pkg::LAST_SLOT && !$past(reset)
         |-> slot_ff == $past(slot_ff) + 1'b1)
      else $error("corner sequencer skipped a slot");

endmodule

// ===== rtl/core/sphere_quad_vertex_generator.sv =====
// Generates the six vertices of one UV-sphere quad per request transaction: (stack, slice)
// in, then corners in the order 01, 02, 11, 02, 12, 11 out, each with a Q8.8 position and
// a Q1.15 unit normal, corner_slot 0..5 and run_last on the sixth. Requests land in a
// two-entry queue, so a new one is taken while results are still stalled at the output.
// The corner sequencer issues one vertex per cycle while the output is not stalled, so a
// steady stream of requests gives one vertex per cycle at the output. Each vertex then
// passes through the registered table lookup, normal multiply and position multiply
// stages in that order before it appears at the output.
// An index at or beyond STACKS or SLICES sets index_error and zero geometry on all six
// vertices. sphere_radius (unsigned Q8.8, 1.0 after reset) may be written only while idle.
module sphere_quad_vertex_generator #(
   parameter int STACKS = sqvg_pkg::DEF_STACKS,
   parameter int SLICES = sqvg_pkg::DEF_SLICES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sqvg_pkg::RADIUS_W-1:0]        csr_sphere_radius,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sqvg_pkg::IDX_W-1:0]           req_stack_index,
   input  logic [sqvg_pkg::IDX_W-1:0]           req_slice_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sqvg_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [sqvg_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [sqvg_pkg::POS_W-1:0]    rsp_pos_z,
   output logic signed [sqvg_pkg::NORM_W-1:0]   rsp_norm_x,
   output logic signed [sqvg_pkg::NORM_W-1:0]   rsp_norm_y,
   output logic signed [sqvg_pkg::NORM_W-1:0]   rsp_norm_z,
   output logic [sqvg_pkg::SLOT_W-1:0]          rsp_corner_slot,
   output logic                                 rsp_index_error,
   output logic                                 rsp_run_last
);

   logic [sqvg_pkg::RADIUS_W-1:0] radius_ff;
   logic                          head_valid;
   sqvg_pkg::item_type            head;
   logic                          head_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= sqvg_pkg::RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_sphere_radius;
      end
   end

   sqvg_front #(
      .STACKS (STACKS),
      .SLICES (SLICES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stack_index (req_stack_index),
      .req_slice_index (req_slice_index),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop)
   );

   sqvg_back #(
      .STACKS (STACKS),
      .SLICES (SLICES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop),
      .radius          (radius_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_norm_x      (rsp_norm_x),
      .rsp_norm_y      (rsp_norm_y),
      .rsp_norm_z      (rsp_norm_z),
      .rsp_corner_slot (rsp_corner_slot),
      .rsp_index_error (rsp_index_error),
      .rsp_run_last    (rsp_run_last)
   );

endmodule
